>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the converter checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent holds at the edge after a reset cycle
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// constants, widths and types shared by the rgb to hsl converter
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int unsigned CH_W          = 8;
  localparam int unsigned MAX_VALUE     = 255;
  localparam int unsigned HUE_FRAC_BITS = 6;

  // largest value a channel can hold after clamping
  localparam int unsigned MAX_CH = (MAX_VALUE < 255) ? MAX_VALUE : 255;

  localparam int unsigned HUE_W = 15;
  localparam int unsigned SAT_W = 16;
  localparam int unsigned SUM_W = 9;

  localparam int unsigned HUE_SCALE = 60 * (1 << HUE_FRAC_BITS);
  localparam int unsigned HUE_FULL  = 6 * HUE_SCALE;
  localparam int unsigned SAT_ONE   = 65535;

  // hue numerator k*d + num after wrap, 0 .. 6*d - 1
  localparam int unsigned H_W = $clog2(6 * MAX_CH + 1);

  localparam int unsigned HUE_DVD_W = $clog2(2 * 6 * MAX_CH * HUE_SCALE + MAX_CH + 1);
  localparam int unsigned SAT_DVD_W = $clog2(2 * MAX_CH * SAT_ONE + MAX_CH + 1);
  localparam int unsigned DVD_W     = (HUE_DVD_W > SAT_DVD_W) ? HUE_DVD_W : SAT_DVD_W;
  localparam int unsigned DVS_W     = $clog2(2 * MAX_CH + 1);

  // one quotient bit per stage, wide enough for both quotients
  localparam int unsigned HUE_Q_W = $clog2(HUE_FULL + 1);
  localparam int unsigned QUOT_W  = (HUE_Q_W > SAT_W) ? HUE_Q_W : SAT_W;

  typedef struct packed {
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SUM_W-1:0] sum;
  } hsl_t;

endpackage

>>> rtl/core/rgb_to_hsl_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_core
// pipelined rgb to hsl pixel converter
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_stall is low and returns hue (1/64
// degree), saturation (times 65535) and the sum of the largest and smallest
// channel. From acceptance a pixel passes two operand stages, then two
// 16-stage dividers running side by side (one quotient bit per stage), then
// the output register. The converter holds no state between pixels and
// needs no setup after reset. pixel_stall rises only when the output
// register and its skid entry are both full.
module rgb_to_hsl_converter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [rth_pkg::CH_W-1:0]      red,
  input  logic [rth_pkg::CH_W-1:0]      green,
  input  logic [rth_pkg::CH_W-1:0]      blue,
  output logic                          hsl_valid,
  input  logic                          hsl_stall,
  output logic [rth_pkg::HUE_W-1:0]     hue,
  output logic [rth_pkg::SAT_W-1:0]     saturation,
  output logic [rth_pkg::SUM_W-1:0]     lightness_sum
);

  localparam int unsigned QUOT_W = rth_pkg::QUOT_W;
  localparam int unsigned SUM_W  = rth_pkg::SUM_W;
  localparam int unsigned HUE_W  = rth_pkg::HUE_W;
  localparam int unsigned SAT_W  = rth_pkg::SAT_W;

  logic              en;
  logic              req_valid;
  logic [SUM_W-1:0]  req_sum;
  rth_pkg::div_req_t hue_req, sat_req;
  logic [QUOT_W-1:0] hue_q, sat_q, hue_fix;
  rth_pkg::hsl_t     result;

  assign pixel_stall = !en;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (pixel_valid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .req_valid (req_valid),
    .req_sum   (req_sum),
    .hue_req   (hue_req),
    .sat_req   (sat_req)
  );

  rth_div u_hue_div (
    .clk  (clk),
    .en   (en),
    .req  (hue_req),
    .quot (hue_q)
  );

  rth_div u_sat_div (
    .clk  (clk),
    .en   (en),
    .req  (sat_req),
    .quot (sat_q)
  );

  // valid and lightness travel alongside the divider stages
  logic             vld [QUOT_W];
  logic [SUM_W-1:0] sum [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= (k == 0) ? req_valid : vld[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sum[k] <= (k == 0) ? req_sum : sum[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // hue that rounds up to a full turn wraps to zero
  assign hue_fix = (hue_q >= QUOT_W'(rth_pkg::HUE_FULL)) ? '0 : hue_q;

  assign result.hue = hue_fix[HUE_W-1:0];
  assign result.sat = sat_q[SAT_W-1:0];
  assign result.sum = sum[QUOT_W-1];

  rth_out u_out (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .push_valid    (vld[QUOT_W-1]),
    .push_data     (result),
    .hsl_valid     (hsl_valid),
    .hsl_stall     (hsl_stall),
    .hue           (hue),
    .saturation    (saturation),
    .lightness_sum (lightness_sum)
  );

endmodule

>>> rtl/core/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front
// two pipeline stages: channel extremes, then divider operand setup
// ----------------------------------------------------------------------------
module rth_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid,
  input  logic [rth_pkg::CH_W-1:0]      red,
  input  logic [rth_pkg::CH_W-1:0]      green,
  input  logic [rth_pkg::CH_W-1:0]      blue,
  output logic                          req_valid,
  output logic [rth_pkg::SUM_W-1:0]     req_sum,
  output rth_pkg::div_req_t             hue_req,
  output rth_pkg::div_req_t             sat_req
);

  localparam int unsigned CH_W  = rth_pkg::CH_W;
  localparam int unsigned SUM_W = rth_pkg::SUM_W;
  localparam int unsigned H_W   = rth_pkg::H_W;
  localparam int unsigned HS_W  = H_W + 1;
  localparam int unsigned DVD_W = rth_pkg::DVD_W;
  localparam int unsigned DVS_W = rth_pkg::DVS_W;
  localparam int unsigned CMP_W = 17;

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] res;
    res = v;
    if (CMP_W'(v) > CMP_W'(rth_pkg::MAX_VALUE)) begin
      res = CH_W'(rth_pkg::MAX_CH);
    end
    return res;
  endfunction

  // stage 1
  logic [CH_W-1:0] r, g, b, mx, mn;
  logic [1:0] sec;
  logic signed [CH_W:0] num;

  always_comb begin
    r = clamp_ch(red);
    g = clamp_ch(green);
    b = clamp_ch(blue);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // ties go to red, then green
    if (mx == r) begin
      sec = SEC_RED;
      num = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (mx == g) begin
      sec = SEC_GREEN;
      num = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sec = SEC_BLUE;
      num = $signed({1'b0, r}) - $signed({1'b0, g});
    end
  end

  logic                 s1_valid;
  logic [1:0]           s1_sec;
  logic signed [CH_W:0] s1_num;
  logic [CH_W-1:0]      s1_d;
  logic [SUM_W-1:0]     s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sec <= sec;
      s1_num <= num;
      s1_d   <= mx - mn;
      s1_sum <= SUM_W'(mx) + SUM_W'(mn);
    end
  end

  // stage 2
  logic signed [HS_W-1:0] kd, h;
  logic [H_W-1:0]         hv;
  logic [CH_W-1:0]        den;
  rth_pkg::div_req_t      hue_next, sat_next;

  always_comb begin
    case (s1_sec)
      SEC_RED:   kd = '0;
      SEC_GREEN: kd = $signed(HS_W'(s1_d) << 1);
      SEC_BLUE:  kd = $signed(HS_W'(s1_d) << 2);
      default:   kd = '0;
    endcase
    h = kd + HS_W'(s1_num);
    // negative hue wraps by a full turn
    if (h < 0) begin
      h = h + $signed(HS_W'(s1_d) * HS_W'(6));
    end
    hv = h[H_W-1:0];

    if (s1_sum <= SUM_W'(rth_pkg::MAX_CH)) begin
      den = s1_sum[CH_W-1:0];
    end else begin
      den = CH_W'(SUM_W'(2 * rth_pkg::MAX_CH) - s1_sum);
    end

    hue_next.dividend = DVD_W'(hv) * DVD_W'(2 * rth_pkg::HUE_SCALE) + DVD_W'(s1_d);
    hue_next.divisor  = DVS_W'({s1_d, 1'b0});
    sat_next.dividend = DVD_W'(s1_d) * DVD_W'(2 * rth_pkg::SAT_ONE) + DVD_W'(den);
    sat_next.divisor  = DVS_W'({den, 1'b0});

    // grey pixel: force both quotients to zero
    if (s1_d == '0) begin
      hue_next.dividend = '0;
      hue_next.divisor  = DVS_W'(1);
      sat_next.dividend = '0;
      sat_next.divisor  = DVS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (en) begin
      req_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_sum <= s1_sum;
      hue_req <= hue_next;
      sat_req <= sat_next;
    end
  end

endmodule

>>> rtl/core/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rth_div (
  input  logic                          clk,
  input  logic                          en,
  input  rth_pkg::div_req_t             req,
  output logic [rth_pkg::QUOT_W-1:0]    quot
);

  localparam int unsigned QUOT_W = rth_pkg::QUOT_W;
  localparam int unsigned DVS_W  = rth_pkg::DVS_W;

  // sh holds the unused dividend bits on top and the quotient bits below
  logic [DVS_W-1:0]  rem [QUOT_W];
  logic [DVS_W-1:0]  dvs [QUOT_W];
  logic [QUOT_W-1:0] sh  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [DVS_W-1:0]  src_rem;
    logic [DVS_W-1:0]  src_dvs;
    logic [QUOT_W-1:0] src_sh;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      // upper dividend part is below the divisor since the quotient fits
      assign src_rem = req.dividend[QUOT_W+DVS_W-1:QUOT_W];
      assign src_dvs = req.divisor;
      assign src_sh  = req.dividend[QUOT_W-1:0];
    end else begin : g_next
      assign src_rem = rem[k-1];
      assign src_dvs = dvs[k-1];
      assign src_sh  = sh[k-1];
    end

    assign trial = {src_rem, src_sh[QUOT_W-1]};
    assign diff  = trial - {1'b0, src_dvs};
    assign take  = (trial >= {1'b0, src_dvs});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvs[k] <= src_dvs;
        sh[k]  <= {src_sh[QUOT_W-2:0], take};
      end
    end
  end

  assign quot = sh[QUOT_W-1];

endmodule

>>> rtl/core/rth_out.sv
// ----------------------------------------------------------------------------
// rth_out
// output register with a skid entry; holds the pipeline while both are full
// ----------------------------------------------------------------------------
module rth_out (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          en,
  input  logic                          push_valid,
  input  rth_pkg::hsl_t                 push_data,
  output logic                          hsl_valid,
  input  logic                          hsl_stall,
  output logic [rth_pkg::HUE_W-1:0]     hue,
  output logic [rth_pkg::SAT_W-1:0]     saturation,
  output logic [rth_pkg::SUM_W-1:0]     lightness_sum
);

  rth_pkg::hsl_t main_data, skid_data;
  logic          skid_valid;
  logic          push, pop;

  assign en   = !skid_valid;
  assign push = en && push_valid;
  assign pop  = hsl_valid && !hsl_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (hsl_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        hsl_valid <= 1'b1;
      end
    end else if (pop) begin
      hsl_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push) begin
      if (hsl_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  assign hue           = main_data.hue;
  assign saturation    = main_data.sat;
  assign lightness_sum = main_data.sum;

endmodule

>>> rtl/core/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rth_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pixel_stall,
  input logic                          hsl_valid,
  input logic                          hsl_stall,
  input logic [rth_pkg::HUE_W-1:0]     hue,
  input logic [rth_pkg::SAT_W-1:0]     saturation,
  input logic [rth_pkg::SUM_W-1:0]     lightness_sum
);

  localparam int unsigned HUE_W = rth_pkg::HUE_W;
  localparam int unsigned OUT_W = rth_pkg::HUE_W + rth_pkg::SAT_W + rth_pkg::SUM_W;

  logic [OUT_W-1:0] out_word;

  assign out_word = {hue, saturation, lightness_sum};

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, hsl_valid && hsl_stall, hsl_valid)

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst, hsl_valid && hsl_stall, $stable(out_word))

  // hue stays below a full turn
  `ASSERT_HOLDS(a_hue_range, clk, rst, !hsl_valid || (hue < HUE_W'(rth_pkg::HUE_FULL)))

  // input backs up only while a result waits at the output
  `ASSERT_HOLDS(a_stall_cause, clk, rst, !pixel_stall || hsl_valid)

  // nothing is offered right after reset
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !hsl_valid && !pixel_stall)

endmodule

bind rgb_to_hsl_converter_core rth_checker u_rth_checker (.*);

>>> bench/tb_rgb_to_hsl_converter_core.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_converter_core
// self-checking bench for the pipelined rgb to hsl pixel converter
// ----------------------------------------------------------------------------
// A queue of pixels, directed corner cases first and then random pixels, feeds
// a driver that offers one request at a time with random gaps. A monitor
// predicts hue, saturation and lightness sum for every accepted pixel and
// compares each returned result, in order, against the oldest prediction.
// The receive side stalls at random. Now and then the driver holds off until
// every predicted result has come back.
module tb_rgb_to_hsl_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [rth_pkg::CH_W-1:0] r;
    logic [rth_pkg::CH_W-1:0] g;
    logic [rth_pkg::CH_W-1:0] b;
    bit                       drain;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       pixel_valid = 1'b0;
  logic                       pixel_stall;
  logic [rth_pkg::CH_W-1:0]   red = '0;
  logic [rth_pkg::CH_W-1:0]   green = '0;
  logic [rth_pkg::CH_W-1:0]   blue = '0;
  logic                       hsl_valid;
  logic                       hsl_stall = 1'b0;
  logic [rth_pkg::HUE_W-1:0]  hue;
  logic [rth_pkg::SAT_W-1:0]  saturation;
  logic [rth_pkg::SUM_W-1:0]  lightness_sum;

  pixel_req_t    pending_pixels[$];
  rth_pkg::hsl_t hsl_expected[$];

  int  mismatch_count = 0;
  bit  pix_taken = 1'b0;
  bit  res_taken = 1'b0;
  int  tx_gap_left = 0;
  int  rx_stall_left = 0;
  bit  tx_bursty = 1'b0;
  bit  rx_bursty = 1'b0;

  rgb_to_hsl_converter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .hsl_valid     (hsl_valid),
    .hsl_stall     (hsl_stall),
    .hue           (hue),
    .saturation    (saturation),
    .lightness_sum (lightness_sum)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hue, saturation and lightness sum of one pixel
  function automatic rth_pkg::hsl_t predict_hsl(input logic [rth_pkg::CH_W-1:0] r_in,
                                                input logic [rth_pkg::CH_W-1:0] g_in,
                                                input logic [rth_pkg::CH_W-1:0] b_in);
    longint r, g, b, mx, mn, d, sum, scale, num, k, t, q, dev, den, sat, hq;
    rth_pkg::hsl_t res;
    r = (r_in > rth_pkg::MAX_VALUE) ? rth_pkg::MAX_VALUE : r_in;
    g = (g_in > rth_pkg::MAX_VALUE) ? rth_pkg::MAX_VALUE : g_in;
    b = (b_in > rth_pkg::MAX_VALUE) ? rth_pkg::MAX_VALUE : b_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    hq = 0;
    sat = 0;
    if (d != 0) begin
      scale = 60 * (longint'(1) << rth_pkg::HUE_FRAC_BITS);
      // ties go red, then green
      if (mx == r) begin
        num = g - b;
        k = 0;
      end else if (mx == g) begin
        num = b - r;
        k = 2;
      end else begin
        num = r - g;
        k = 4;
      end
      t = (k * d + num) * scale;
      if (t < 0) t = t + 6 * d * scale;
      q = (2 * t + d) / (2 * d);
      if (q >= 6 * scale) q = q - 6 * scale;
      hq = q;
      dev = (sum > rth_pkg::MAX_VALUE) ? (sum - rth_pkg::MAX_VALUE)
                                       : (rth_pkg::MAX_VALUE - sum);
      den = rth_pkg::MAX_VALUE - dev;
      if (den != 0) sat = (2 * d * 65535 + den) / (2 * den);
      if (sat > 65535) sat = 65535;
    end
    res.hue = hq[rth_pkg::HUE_W-1:0];
    res.sat = sat[rth_pkg::SAT_W-1:0];
    res.sum = sum[rth_pkg::SUM_W-1:0];
    return res;
  endfunction

  function automatic void add_pixel(input int r, input int g, input int b,
                                    input bit drain);
    pixel_req_t p;
    p.r = r[rth_pkg::CH_W-1:0];
    p.g = g[rth_pkg::CH_W-1:0];
    p.b = b[rth_pkg::CH_W-1:0];
    p.drain = drain;
    pending_pixels.push_back(p);
  endfunction

  // channel a few steps off a base level, kept in range
  function automatic int near_level(input int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // driver: one request on the port at a time, gap drawn per pixel
  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      nv = pixel_valid;
      if (pixel_valid && pix_taken) begin
        nv = 1'b0;
        if ($urandom_range(0, 63) == 0) tx_bursty = ~tx_bursty;
        tx_gap_left = tx_bursty ? 0 : int'($urandom_range(0, 15));
      end
      if (!nv) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (pending_pixels.size() != 0) begin
          // hold off until the pipeline has fully drained
          if (!pending_pixels[0].drain || hsl_expected.size() == 0) begin
            red   <= pending_pixels[0].r;
            green <= pending_pixels[0].g;
            blue  <= pending_pixels[0].b;
            void'(pending_pixels.pop_front());
            nv = 1'b1;
          end
        end
      end
      pixel_valid <= nv;
    end
  end

  // receive side stall, drawn per result
  always @(negedge clk) begin
    if (rst) begin
      hsl_stall <= 1'b0;
    end else begin
      if (res_taken) begin
        if ($urandom_range(0, 63) == 0) rx_bursty = ~rx_bursty;
        rx_stall_left = rx_bursty ? 0 : int'($urandom_range(0, 15));
      end
      if (rx_stall_left > 0) begin
        hsl_stall <= 1'b1;
        rx_stall_left--;
      end else begin
        hsl_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on pixel acceptance, check on result acceptance
  always @(posedge clk) begin
    rth_pkg::hsl_t want;
    pix_taken <= !rst && pixel_valid && !pixel_stall;
    res_taken <= !rst && hsl_valid && !hsl_stall;
    if (!rst) begin
      if (hsl_valid && !hsl_stall) begin
        if (hsl_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: hue %0d sat %0d sum %0d",
                     hue, saturation, lightness_sum);
        end else begin
          want = hsl_expected.pop_front();
          if (hue !== want.hue || saturation !== want.sat ||
              lightness_sum !== want.sum) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: hue exp %0d got %0d, sat exp %0d got %0d, sum exp %0d got %0d",
                       want.hue, hue, want.sat, saturation, want.sum, lightness_sum);
          end
        end
      end
      if (pixel_valid && !pixel_stall)
        hsl_expected.push_back(predict_hsl(red, green, blue));
    end
  end

  initial begin
    int kind, base, a, b2;
    // directed corners
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(128, 128, 128, 1'b0);
    add_pixel(255, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 1'b0);
    add_pixel(0, 0, 255, 1'b0);
    add_pixel(255, 255, 0, 1'b0);
    add_pixel(0, 255, 255, 1'b0);
    add_pixel(255, 0, 255, 1'b0);
    // red largest, hue just under a full turn
    add_pixel(255, 0, 1, 1'b0);
    add_pixel(1, 0, 0, 1'b0);
    add_pixel(255, 254, 254, 1'b0);
    add_pixel(254, 255, 255, 1'b0);
    add_pixel(200, 100, 200, 1'b0);
    add_pixel(100, 200, 200, 1'b0);
    add_pixel(200, 200, 100, 1'b0);
    add_pixel(170, 85, 0, 1'b0);
    add_pixel(0, 1, 255, 1'b0);
    add_pixel(127, 128, 0, 1'b0);
    add_pixel(85, 170, 255, 1'b0);
    add_pixel(1, 255, 254, 1'b0);
    add_pixel(0, 0, 1, 1'b0);
    add_pixel(255, 255, 254, 1'b1);
    // random pixels
    for (int i = 0; i < 1700; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), 1'b0);
      end else if (kind <= 6) begin
        base = $urandom_range(0, 255);
        add_pixel(near_level(base), near_level(base), near_level(base), 1'b0);
      end else if (kind == 7) begin
        a = $urandom_range(0, 255);
        b2 = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
          0: add_pixel(a, a, b2, 1'b0);
          1: add_pixel(a, b2, a, 1'b0);
          default: add_pixel(b2, a, a, 1'b0);
        endcase
      end else if (kind == 8) begin
        add_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 255),
                  $urandom_range(0, 1) * 255, 1'b0);
      end else begin
        base = $urandom_range(0, 255);
        add_pixel(base, base, base, 1'b0);
      end
      if (i == 0 || $urandom_range(0, 99) == 0) pending_pixels[$].drain = 1'b1;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() != 0 || pixel_valid) @(posedge clk);
    while (hsl_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
